### rtl/gfve_pkg.sv
`timescale 1ns / 1ps
package gfve_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CNT_W = 32;
   localparam int NUM_W = 65;
   localparam int DEN_W = 128;
   localparam int FIFO_DEPTH = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_POS_COV_XX = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_POS_COV_XY = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_POS_COV_YX = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_POS_COV_YY = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_ABS_LIMIT = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_INNOV_LIMIT = 3'd5;

   localparam logic [30:0] ABS_LIMIT_RESET = 31'd655360000;
   localparam logic [31:0] INNOV_LIMIT_RESET = 32'd655360;

   // quotient order in the back end
   localparam logic [2:0] OP_VEL_X = 3'd0;
   localparam logic [2:0] OP_VEL_Y = 3'd1;
   localparam logic [2:0] OP_COV_FIRST = 3'd2;
   localparam logic [2:0] OP_LAST = 3'd5;

   typedef struct packed {
      logic signed [31:0] fix_x;
      logic signed [31:0] fix_y;
      logic signed [31:0] predicted_x;
      logic [31:0]        tick_period;
   } req_type;

   typedef struct packed {
      logic               fix_accepted;
      logic signed [31:0] held_x;
      logic signed [31:0] held_y;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] vel_cov_xx;
      logic signed [31:0] vel_cov_xy;
      logic signed [31:0] vel_cov_yx;
      logic signed [31:0] vel_cov_yy;
      logic               vel_updated;
      logic               vel_valid;
      logic               saturated;
   } rsp_type;

   typedef struct packed {
      logic [3:0][31:0] pos_cov;
      logic [30:0]      abs_limit;
      logic [31:0]      innov_limit;
   } csr_type;

   typedef struct packed {
      logic             accepted;
      logic [31:0]      held_x;
      logic [31:0]      held_y;
      logic             update;
      logic [CNT_W-1:0] cnt;
      logic [31:0]      tick_period;
      logic [32:0]      delta_x;
      logic [32:0]      delta_y;
   } job_type;

endpackage

### rtl/gated_fix_velocity_estimator.sv
`timescale 1ns / 1ps
// Velocity estimator from gated position fixes. Each request transaction is one tick; each
// tick yields exactly one response. The front end gates the fix and tracks the two-fix buffer
// and tick count in the cycle the request is taken, then queues the work (two entries). A tick
// without a velocity update goes from the back end's idle state straight to output. A tick that
// completes a fix pair uses the shared 32x32 multiplier for ticks*dt and then its square, then
// six quotients one after another through one radix-2 restoring divider, which sets the rate.
// Configuration writes are taken every cycle (csr_ready is always high) and must only be issued
// while no tick is in flight.
module gated_fix_velocity_estimator #(
   parameter int TICK_COUNT_WIDTH = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_push,
   output logic                                  req_full,
   input  gfve_pkg::req_type                     req_data,
   output logic                                  rsp_empty,
   input  logic                                  rsp_pop,
   output gfve_pkg::rsp_type                     rsp_data,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [gfve_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [31:0]                           csr_data
);
   gfve_pkg::csr_type csr_ff, csr_in;
   gfve_pkg::job_type job_wr, job_rd;
   logic              job_push, job_full, job_pop, job_empty;

   assign csr_ready = 1'b1;

   always_comb begin
      csr_in = csr_ff;
      if (csr_valid) begin
         case (csr_index)
            gfve_pkg::CSR_POS_COV_XX: csr_in.pos_cov[0] = csr_data;
            gfve_pkg::CSR_POS_COV_XY: csr_in.pos_cov[1] = csr_data;
            gfve_pkg::CSR_POS_COV_YX: csr_in.pos_cov[2] = csr_data;
            gfve_pkg::CSR_POS_COV_YY: csr_in.pos_cov[3] = csr_data;
            gfve_pkg::CSR_ABS_LIMIT: csr_in.abs_limit = csr_data[30:0];
            gfve_pkg::CSR_INNOV_LIMIT: csr_in.innov_limit = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.pos_cov <= '0;
         csr_ff.abs_limit <= gfve_pkg::ABS_LIMIT_RESET;
         csr_ff.innov_limit <= gfve_pkg::INNOV_LIMIT_RESET;
      end else begin
         csr_ff <= csr_in;
      end
   end

   gfve_front #(.TICK_COUNT_WIDTH(TICK_COUNT_WIDTH)) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .csr      (csr_ff),
      .job_push (job_push),
      .job      (job_wr),
      .job_full (job_full)
   );

   gfve_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_wr),
      .full      (job_full),
      .pop       (job_pop),
      .pop_data  (job_rd),
      .empty     (job_empty)
   );

   gfve_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_empty (job_empty),
      .job       (job_rd),
      .job_pop   (job_pop),
      .csr       (csr_ff),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );
endmodule

### rtl/gfve_fifo.sv
`timescale 1ns / 1ps
module gfve_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  gfve_pkg::job_type push_data,
   output logic              full,
   input  logic              pop,
   output gfve_pkg::job_type pop_data,
   output logic              empty
);
   localparam int AW = $clog2(gfve_pkg::FIFO_DEPTH);

   gfve_pkg::job_type     mem_ff [gfve_pkg::FIFO_DEPTH];
   logic [AW-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [AW:0]           count_ff, count_in;
   logic                  do_push, do_pop;

   assign full = (count_ff == (AW+1)'(gfve_pkg::FIFO_DEPTH));
   assign empty = (count_ff == '0);
   assign do_push = push & !full;
   assign do_pop = pop & !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff + (AW+1)'(do_push) - (AW+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end
endmodule

### rtl/gfve_front.sv
`timescale 1ns / 1ps
module gfve_front #(
   parameter int TICK_COUNT_WIDTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  gfve_pkg::req_type req_data,
   input  gfve_pkg::csr_type csr,
   output logic              job_push,
   output gfve_pkg::job_type job,
   input  logic              job_full
);
   localparam int CW = gfve_pkg::CNT_W;

   logic                        held_ff, held_in;
   logic [TICK_COUNT_WIDTH-1:0] cnt_ff, cnt_in, cnt_inc;
   logic [31:0]                 first_x_ff, first_x_in;
   logic [31:0]                 first_y_ff, first_y_in;
   logic [31:0]                 hold_x_ff, hold_x_in;
   logic [31:0]                 hold_y_ff, hold_y_in;
   logic [32:0]                 x_ext, mag, innov;
   logic                        accept, update, take;

   assign req_full = job_full;
   assign take = req_push & !job_full;
   assign job_push = take;

   always_comb begin
      x_ext = {req_data.fix_x[31], req_data.fix_x};
      mag = x_ext[32] ? 33'd0 - x_ext : x_ext;
      innov = x_ext - {req_data.predicted_x[31], req_data.predicted_x};
      accept = (req_data.fix_x != '0) && (mag < {2'b00, csr.abs_limit}) &&
               ($signed(innov) < $signed({csr.innov_limit[31], csr.innov_limit}));
      update = accept & held_ff;
      // tick count saturates at all ones
      cnt_inc = (cnt_ff != '1) ? cnt_ff + 1'b1 : cnt_ff;

      held_in = held_ff;
      cnt_in = cnt_ff;
      first_x_in = first_x_ff;
      first_y_in = first_y_ff;
      hold_x_in = hold_x_ff;
      hold_y_in = hold_y_ff;
      if (take) begin
         if (accept) begin
            hold_x_in = req_data.fix_x;
            hold_y_in = req_data.fix_y;
         end
         if (update) begin
            held_in = 1'b0;
         end else if (accept) begin
            held_in = 1'b1;
            cnt_in = '0;
            first_x_in = req_data.fix_x;
            first_y_in = req_data.fix_y;
         end else if (held_ff) begin
            cnt_in = cnt_inc;
         end
      end

      job.accepted = accept;
      job.held_x = hold_x_in;
      job.held_y = hold_y_in;
      job.update = update;
      job.cnt = CW'(cnt_inc);
      job.tick_period = req_data.tick_period;
      job.delta_x = x_ext - {first_x_ff[31], first_x_ff};
      job.delta_y = {req_data.fix_y[31], req_data.fix_y} - {first_y_ff[31], first_y_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= 1'b0;
         hold_x_ff <= '0;
         hold_y_ff <= '0;
      end else begin
         held_ff <= held_in;
         hold_x_ff <= hold_x_in;
         hold_y_ff <= hold_y_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      first_x_ff <= first_x_in;
      first_y_ff <= first_y_in;
   end
endmodule

### rtl/gfve_div.sv
`timescale 1ns / 1ps
module gfve_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [gfve_pkg::NUM_W-1:0]   num,
   input  logic [gfve_pkg::DEN_W-1:0]   den,
   input  logic                         neg,
   output logic                         done,
   output logic [31:0]                  quot,
   output logic                         sat
);
   localparam int NW = gfve_pkg::NUM_W;
   localparam int SW = NW + 31;

   typedef enum logic [2:0] {
      D_IDLE = 3'b001,
      D_RUN  = 3'b010,
      D_DONE = 3'b100
   } div_state_type;

   div_state_type state_ff, state_in;
   logic [NW-1:0] rem_ff, rem_in;
   logic [SW-1:0] dsh_ff, dsh_in;
   logic [31:0]   q_ff, q_in;
   logic [4:0]    step_ff, step_in;
   logic          neg_ff, neg_in;
   logic          zero_ff, zero_in;
   logic          over_ff, over_in;
   logic          ge;
   logic [31:0]   limv, qm;
   logic          big;

   assign ge = {31'b0, rem_ff} >= dsh_ff;

   always_comb begin
      state_in = state_ff;
      rem_in = rem_ff;
      dsh_in = dsh_ff;
      q_in = q_ff;
      step_in = step_ff;
      neg_in = neg_ff;
      zero_in = zero_ff;
      over_in = over_ff;
      case (state_ff)
         D_IDLE: begin
            if (start) begin
               neg_in = neg;
               zero_in = 1'b0;
               over_in = 1'b0;
               q_in = '0;
               rem_in = num;
               dsh_in = {den[NW-1:0], 31'b0};
               step_in = '0;
               state_in = D_DONE;
               if (den == '0) begin
                  // zero divisor: limit by sign, zero for a zero numerator
                  zero_in = 1'b1;
                  over_in = (num != '0);
               end else if (den[gfve_pkg::DEN_W-1:NW] != '0) begin
                  q_in = '0;
               end else if ({32'b0, num} >= {den[NW-1:0], 32'b0}) begin
                  over_in = 1'b1;
               end else begin
                  state_in = D_RUN;
               end
            end
         end
         D_RUN: begin
            if (ge) begin
               rem_in = rem_ff - dsh_ff[NW-1:0];
            end
            q_in = {q_ff[30:0], ge};
            dsh_in = dsh_ff >> 1;
            step_in = step_ff + 1'b1;
            if (step_ff == 5'd31) begin
               state_in = D_DONE;
            end
         end
         D_DONE: begin
            state_in = D_IDLE;
         end
         default: begin
            state_in = D_IDLE;
         end
      endcase
   end

   always_comb begin
      limv = neg_ff ? 32'h8000_0000 : 32'h7fff_ffff;
      big = over_ff | (q_ff > limv);
      qm = big ? limv : q_ff;
      quot = neg_ff ? 32'd0 - qm : qm;
      sat = big | zero_ff;
      done = (state_ff == D_DONE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      q_ff <= q_in;
      step_ff <= step_in;
      neg_ff <= neg_in;
      zero_ff <= zero_in;
      over_ff <= over_in;
   end
endmodule

### rtl/gfve_back.sv
`timescale 1ns / 1ps
module gfve_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_empty,
   input  gfve_pkg::job_type job,
   output logic              job_pop,
   input  gfve_pkg::csr_type csr,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output gfve_pkg::rsp_type rsp_data
);
   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_MUL  = 5'b00010,
      S_SQR  = 5'b00100,
      S_DIV  = 5'b01000,
      S_OUT  = 5'b10000
   } state_type;

   state_type                    state_ff, state_in;
   gfve_pkg::job_type            job_ff, job_in;
   logic [63:0]                  d_ff, d_in;
   logic [127:0]                 den2_ff, den2_in;
   logic [1:0]                   sq_ff, sq_in;
   logic [2:0]                   op_ff, op_in;
   logic                         issued_ff, issued_in;
   logic                         sat_ff, sat_in;
   logic                         valid_ff, valid_in;
   logic                         out_full_ff, out_full_in;
   logic [1:0][31:0]             vel_ff, vel_in;
   logic [3:0][31:0]             cov_ff, cov_in;
   gfve_pkg::rsp_type            rsp_ff, rsp_in;
   logic [31:0]                  mul_a, mul_b;
   logic [63:0]                  prod;
   logic [32:0]                  delta, dmag;
   logic [31:0]                  rval;
   logic [32:0]                  rmag;
   logic [1:0]                   csel;
   logic [gfve_pkg::NUM_W-1:0]   div_num;
   logic [gfve_pkg::DEN_W-1:0]   div_den;
   logic                         div_neg, div_start, div_done, div_sat;
   logic [31:0]                  div_q;

   assign rsp_empty = !out_full_ff;
   assign rsp_data = rsp_ff;

   // one shared 32x32 multiplier: count times period, then the square
   always_comb begin
      mul_a = job_ff.cnt;
      mul_b = job_ff.tick_period;
      if (state_ff == S_SQR) begin
         case (sq_ff)
            2'd0: begin
               mul_a = d_ff[31:0];
               mul_b = d_ff[31:0];
            end
            2'd1: begin
               mul_a = d_ff[31:0];
               mul_b = d_ff[63:32];
            end
            default: begin
               mul_a = d_ff[63:32];
               mul_b = d_ff[63:32];
            end
         endcase
      end
      prod = 64'(mul_a) * 64'(mul_b);
   end

   always_comb begin
      delta = (op_ff == gfve_pkg::OP_VEL_Y) ? job_ff.delta_y : job_ff.delta_x;
      dmag = delta[32] ? 33'd0 - delta : delta;
      csel = 2'(op_ff - gfve_pkg::OP_COV_FIRST);
      rval = csr.pos_cov[csel];
      rmag = rval[31] ? 33'd0 - {1'b1, rval} : {1'b0, rval};
      if (op_ff < gfve_pkg::OP_COV_FIRST) begin
         div_num = {16'b0, dmag, 16'b0};
         div_den = {64'b0, d_ff};
         div_neg = delta[32];
      end else begin
         div_num = {rmag[31:0], 1'b0, 32'b0};
         div_den = den2_ff;
         div_neg = rval[31];
      end
   end

   gfve_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .neg   (div_neg),
      .done  (div_done),
      .quot  (div_q),
      .sat   (div_sat)
   );

   always_comb begin
      state_in = state_ff;
      job_in = job_ff;
      d_in = d_ff;
      den2_in = den2_ff;
      sq_in = sq_ff;
      op_in = op_ff;
      issued_in = issued_ff;
      sat_in = sat_ff;
      valid_in = valid_ff;
      out_full_in = out_full_ff;
      vel_in = vel_ff;
      cov_in = cov_ff;
      rsp_in = rsp_ff;
      job_pop = 1'b0;
      div_start = 1'b0;
      if (rsp_pop && out_full_ff) begin
         out_full_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            if (!job_empty) begin
               job_pop = 1'b1;
               job_in = job;
               sat_in = 1'b0;
               state_in = job.update ? S_MUL : S_OUT;
            end
         end
         S_MUL: begin
            d_in = prod;
            sq_in = '0;
            state_in = S_SQR;
         end
         S_SQR: begin
            case (sq_ff)
               2'd0: den2_in = {64'b0, prod};
               2'd1: den2_in = den2_ff + {31'b0, prod, 33'b0};
               default: den2_in = den2_ff + {prod, 64'b0};
            endcase
            sq_in = sq_ff + 1'b1;
            if (sq_ff == 2'd2) begin
               op_in = gfve_pkg::OP_VEL_X;
               issued_in = 1'b0;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (!issued_ff) begin
               div_start = 1'b1;
               issued_in = 1'b1;
            end else if (div_done) begin
               issued_in = 1'b0;
               sat_in = sat_ff | div_sat;
               if (op_ff < gfve_pkg::OP_COV_FIRST) begin
                  vel_in[op_ff[0]] = div_q;
               end else begin
                  cov_in[csel] = div_q;
               end
               op_in = op_ff + 1'b1;
               if (op_ff == gfve_pkg::OP_LAST) begin
                  state_in = S_OUT;
               end
            end
         end
         S_OUT: begin
            if (!out_full_ff) begin
               out_full_in = 1'b1;
               valid_in = valid_ff | job_ff.update;
               rsp_in.fix_accepted = job_ff.accepted;
               rsp_in.held_x = job_ff.held_x;
               rsp_in.held_y = job_ff.held_y;
               rsp_in.vel_x = vel_ff[0];
               rsp_in.vel_y = vel_ff[1];
               rsp_in.vel_cov_xx = cov_ff[0];
               rsp_in.vel_cov_xy = cov_ff[1];
               rsp_in.vel_cov_yx = cov_ff[2];
               rsp_in.vel_cov_yy = cov_ff[3];
               rsp_in.vel_updated = job_ff.update;
               rsp_in.vel_valid = valid_ff | job_ff.update;
               rsp_in.saturated = job_ff.update & sat_ff;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         issued_ff <= 1'b0;
         valid_ff <= 1'b0;
         out_full_ff <= 1'b0;
         vel_ff <= '0;
         cov_ff <= '0;
      end else begin
         state_ff <= state_in;
         issued_ff <= issued_in;
         valid_ff <= valid_in;
         out_full_ff <= out_full_in;
         vel_ff <= vel_in;
         cov_ff <= cov_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      d_ff <= d_in;
      den2_ff <= den2_in;
      sq_ff <= sq_in;
      op_ff <= op_in;
      sat_ff <= sat_in;
      rsp_ff <= rsp_in;
   end
endmodule

### rtl/gfve_checker.sv
`timescale 1ns / 1ps
module gfve_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_empty,
   input logic              rsp_pop,
   input gfve_pkg::rsp_type rsp_data
);
   // a waiting response transaction holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_data)))
      else $error("response changed while waiting");

   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("response present after reset");

   a_update_valid: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.vel_updated) |-> rsp_data.vel_valid)
      else $error("update without valid flag");

   a_sat_update: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.saturated) |-> rsp_data.vel_updated)
      else $error("saturation flagged without update");

   // an accepted fix is never zero, so neither is the held x
   a_accept_nonzero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.fix_accepted) |-> (rsp_data.held_x != 0))
      else $error("accepted fix with zero x");
endmodule

bind gated_fix_velocity_estimator gfve_checker u_gfve_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_empty (rsp_empty),
   .rsp_pop   (rsp_pop),
   .rsp_data  (rsp_data)
);
